// File: rtl/mf3_pkg.sv
`timescale 1ns / 1ps
// package for the 3x3 minimum filter: beat types, register indexes and sizes
// no dependencies

package mf3_pkg;

  localparam int unsigned LineDepth = 1024;
  localparam int unsigned LineAw    = $clog2(LineDepth);

  localparam int unsigned PixW   = 8;
  localparam int unsigned FwW    = 11;
  localparam int unsigned FhW    = 16;
  localparam int unsigned CfgW   = 16;
  localparam int unsigned CfgIdxW = 2;

  localparam logic [CfgIdxW-1:0] CfgFrameWidth  = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgFrameHeight = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgBorderFill  = 2'd2;

  localparam logic [FwW-1:0]  FrameWidthRst  = 11'd640;
  localparam logic [FhW-1:0]  FrameHeightRst = 16'd480;
  localparam logic [PixW-1:0] BorderFillRst  = 8'd255;

  localparam logic [FwW-1:0] MaxWidth = FwW'(LineDepth);

  typedef struct packed {
    logic            mode;
    logic [PixW-1:0] pixel;
  } mf3_in_t;

  typedef struct packed {
    logic [PixW-1:0] min_value;
    logic            frame_end;
  } mf3_out_t;

endpackage

// File: rtl/min_filter_3x3_unit.sv
`timescale 1ns / 1ps
// 3x3 minimum filter (grayscale erosion) over a raster pixel stream
// a window's last beat is registered in s1_q, then its result in out_q
// throughput: one beat per cycle unless stalled, set by one store read and write per cycle
// results lag the input by frame_width + 1 beats; drain beats flush the frame tail
// reset: counters cleared, registers at defaults, no clearing pass over the line store
module min_filter_3x3_unit
  import mf3_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgW-1:0]     cfg_data_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  mf3_in_t             in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output mf3_out_t            out_data_o
);

  typedef struct packed {
    logic              emit;
    logic              first_col;
    logic              top_m;
    logic              bot_m;
    logic              lft_m;
    logic              rgt_m;
    logic              last;
    logic [PixW-1:0]   pixel;
    logic [LineAw-1:0] addr;
  } s1_t;

  logic [FwW-1:0]  frame_width_q;
  logic [FhW-1:0]  frame_height_q;
  logic [PixW-1:0] border_fill_q;

  logic [LineAw-1:0] in_col_q, in_col_d;
  logic [FhW:0]      in_row_q, in_row_d;
  logic [LineAw-1:0] out_col_q, out_col_d;
  logic [FhW-1:0]    out_row_q, out_row_d;

  logic      s1_valid_q, s1_valid_d;
  s1_t       s1_q, s1_d;
  logic      out_valid_q, out_valid_d;
  mf3_out_t  out_q;

  logic [2*PixW-1:0] line_mem [LineDepth];
  logic [2*PixW-1:0] rd_q;
  logic [2*PixW-1:0] wr_data;

  logic [PixW-1:0] win_q [3][3];

  logic [FwW-1:0] eff_w;
  logic [FhW-1:0] eff_h;
  logic [FhW:0]   h_ext;
  logic           live, take, emit, last;
  logic           top_m, bot_m, lft_m, rgt_m;
  logic           in_fire, load_s1, s1_go, cfg_clear;
  logic [FwW-1:0] in_col_inc, out_col_inc;

  logic [PixW-1:0] new_col [3];
  logic [PixW-1:0] nb [3][3];
  logic [PixW-1:0] row_min [3];
  logic [PixW-1:0] min_val;

  function automatic logic [PixW-1:0] min3(logic [PixW-1:0] a, logic [PixW-1:0] b,
                                           logic [PixW-1:0] c);
    logic [PixW-1:0] ab;
    ab = (a < b) ? a : b;
    return (ab < c) ? ab : c;
  endfunction

  // effective geometry
  always_comb begin
    if (frame_width_q == '0) begin
      eff_w = FwW'(1);
    end else if (frame_width_q > MaxWidth) begin
      eff_w = MaxWidth;
    end else begin
      eff_w = frame_width_q;
    end
    eff_h = (frame_height_q == '0) ? FhW'(1) : frame_height_q;
    h_ext = {1'b0, eff_h};
  end

  // accept side decisions
  always_comb begin
    live  = in_row_q < h_ext;
    take  = live ? !in_data_i.mode : 1'b1;
    emit  = (in_row_q >= (FhW+1)'(2)) || (in_row_q == (FhW+1)'(1) && in_col_q != '0);
    top_m = out_row_q == '0;
    bot_m = ({1'b0, out_row_q} + (FhW+1)'(1)) >= h_ext;
    lft_m = out_col_q == '0;
    out_col_inc = {1'b0, out_col_q} + FwW'(1);
    in_col_inc  = {1'b0, in_col_q} + FwW'(1);
    rgt_m = out_col_inc >= eff_w;
    last  = bot_m && rgt_m;
  end

  assign s1_go      = s1_valid_q && (!s1_q.emit || !out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || s1_go;
  assign in_fire    = in_valid_i && in_ready_o;
  assign load_s1    = in_fire && take;
  assign cfg_clear  = cfg_we_i &&
                      (cfg_index_i == CfgFrameWidth || cfg_index_i == CfgFrameHeight);

  // position counters
  always_comb begin
    in_col_d  = in_col_q;
    in_row_d  = in_row_q;
    out_col_d = out_col_q;
    out_row_d = out_row_q;
    if (cfg_clear || (load_s1 && emit && last)) begin
      in_col_d  = '0;
      in_row_d  = '0;
      out_col_d = '0;
      out_row_d = '0;
    end else if (load_s1) begin
      if (emit) begin
        if (rgt_m) begin
          out_col_d = '0;
          out_row_d = out_row_q + FhW'(1);
        end else begin
          out_col_d = out_col_inc[LineAw-1:0];
        end
      end
      if (in_col_inc >= eff_w) begin
        in_col_d = '0;
        in_row_d = in_row_q + (FhW+1)'(1);
      end else begin
        in_col_d = in_col_inc[LineAw-1:0];
      end
    end
  end

  always_comb begin
    s1_d.emit      = emit;
    s1_d.first_col = in_col_q == '0;
    s1_d.top_m     = top_m;
    s1_d.bot_m     = bot_m;
    s1_d.lft_m     = lft_m;
    s1_d.rgt_m     = rgt_m;
    s1_d.last      = last;
    s1_d.pixel     = live ? in_data_i.pixel : border_fill_q;
    s1_d.addr      = in_col_q;
    if (load_s1) begin
      s1_valid_d = 1'b1;
    end else if (s1_go) begin
      s1_valid_d = 1'b0;
    end else begin
      s1_valid_d = s1_valid_q;
    end
    if (s1_go && s1_q.emit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_width_q  <= FrameWidthRst;
      frame_height_q <= FrameHeightRst;
      border_fill_q  <= BorderFillRst;
      in_col_q       <= '0;
      in_row_q       <= '0;
      out_col_q      <= '0;
      out_row_q      <= '0;
      s1_valid_q     <= 1'b0;
      out_valid_q    <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          CfgFrameWidth:  frame_width_q  <= cfg_data_i[FwW-1:0];
          CfgFrameHeight: frame_height_q <= cfg_data_i[FhW-1:0];
          CfgBorderFill:  border_fill_q  <= cfg_data_i[PixW-1:0];
          default: ;
        endcase
      end
      in_col_q    <= in_col_d;
      in_row_q    <= in_row_d;
      out_col_q   <= out_col_d;
      out_row_q   <= out_row_d;
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // line store: upper in the high byte, middle in the low byte
  assign wr_data = {rd_q[PixW-1:0], s1_q.pixel};

  always_ff @(posedge clk_i) begin
    if (s1_go) begin
      line_mem[s1_q.addr] <= wr_data;
    end
  end

  // same-address read during a write takes the new data
  always_ff @(posedge clk_i) begin
    if (load_s1) begin
      if (s1_go && s1_q.addr == s1_d.addr) begin
        rd_q <= wr_data;
      end else begin
        rd_q <= line_mem[s1_d.addr];
      end
    end
  end

  // window and minimum
  always_comb begin
    new_col[0] = rd_q[2*PixW-1:PixW];
    new_col[1] = rd_q[PixW-1:0];
    new_col[2] = s1_q.pixel;
    for (int m = 0; m < 3; m++) begin
      for (int n = 0; n < 3; n++) begin
        if (n == 0) begin
          nb[m][n] = win_q[m][1];
        end else if (n == 1) begin
          nb[m][n] = win_q[m][2];
        end else begin
          nb[m][n] = s1_q.first_col ? border_fill_q : new_col[m];
        end
        if ((m == 0 && s1_q.top_m) || (m == 2 && s1_q.bot_m) ||
            (n == 0 && s1_q.lft_m) || (n == 2 && s1_q.rgt_m)) begin
          nb[m][n] = border_fill_q;
        end
      end
      row_min[m] = min3(nb[m][0], nb[m][1], nb[m][2]);
    end
    min_val = min3(row_min[0], row_min[1], row_min[2]);
  end

  always_ff @(posedge clk_i) begin
    if (s1_go) begin
      for (int m = 0; m < 3; m++) begin
        win_q[m][0] <= win_q[m][1];
        win_q[m][1] <= win_q[m][2];
        win_q[m][2] <= new_col[m];
      end
    end
    if (load_s1) begin
      s1_q <= s1_d;
    end
    if (s1_go && s1_q.emit) begin
      out_q.min_value <= min_val;
      out_q.frame_end <= s1_q.last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_in_row_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_row_q <= h_ext + (FhW+1)'(1))
    else $error("input row counter ran past the drain rows");

  a_out_col_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    {1'b0, out_col_q} < eff_w)
    else $error("output column outside the row");

  a_out_row_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_row_q < eff_h)
    else $error("output row outside the frame");

  a_last_clears : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load_s1 && emit && last) |=> (in_row_q == '0 && out_row_q == '0))
    else $error("counters not cleared after the last beat of the frame");

endmodule

// File: test/tb_min_filter_3x3_unit.sv
`timescale 1ns / 1ps
// testbench for min_filter_3x3_unit: a directed table of beats and register writes, then
// random frames, checked against table results or a local model. needs rtl/mf3_pkg.sv
module tb_min_filter_3x3_unit
  import mf3_pkg::*;
();

  localparam logic ModePixel = 1'b0;
  localparam logic ModeDrain = 1'b1;
  localparam int unsigned SettleCycles  = 8;
  localparam int unsigned WatchdogLimit = 2000;
  localparam int unsigned RandomBeats   = 1700;
  localparam int unsigned NumRows       = 29;

  typedef enum logic {RowBeat, RowCfg} row_kind_e;

  typedef struct packed {
    row_kind_e          kind;
    logic [CfgIdxW-1:0] index;
    logic [CfgW-1:0]    value;
    logic               mode;
    logic [PixW-1:0]    pixel;
    logic               typed;
    logic [PixW-1:0]    min_value;
    logic               frame_end;
  } script_row_t;

  typedef struct packed {
    logic     typed;
    mf3_out_t result;
  } beat_note_t;

  localparam beat_note_t NoNote = '0;

  localparam script_row_t Script [NumRows] = '{
    // drain straight after reset
    '{RowBeat, CfgFrameWidth,  16'd0,  ModeDrain, 8'h5A, 1'b0, 8'd0,   1'b0},
    // 3x2 frame, neutral fill
    '{RowCfg,  CfgFrameWidth,  16'd3,  ModePixel, 8'd0,  1'b0, 8'd0,   1'b0},
    '{RowCfg,  CfgFrameHeight, 16'd2,  ModePixel, 8'd0,  1'b0, 8'd0,   1'b0},
    '{RowBeat, CfgFrameWidth,  16'd0,  ModePixel, 8'd10, 1'b0, 8'd0,   1'b0},
    '{RowBeat, CfgFrameWidth,  16'd0,  ModePixel, 8'd20, 1'b0, 8'd0,   1'b0},
    '{RowBeat, CfgFrameWidth,  16'd0,  ModePixel, 8'd30, 1'b0, 8'd0,   1'b0},
    '{RowBeat, CfgFrameWidth,  16'd0,  ModeDrain, 8'hA5, 1'b0, 8'd0,   1'b0},
    '{RowBeat, CfgFrameWidth,  16'd0,  ModePixel, 8'd40, 1'b0, 8'd0,   1'b0},
    '{RowBeat, CfgFrameWidth,  16'd0,  ModePixel, 8'd50, 1'b1, 8'd10,  1'b0},
    '{RowBeat, CfgFrameWidth,  16'd0,  ModePixel, 8'd60, 1'b1, 8'd10,  1'b0},
    '{RowBeat, CfgFrameWidth,  16'd0,  ModeDrain, 8'd0,  1'b1, 8'd20,  1'b0},
    '{RowBeat, CfgFrameWidth,  16'd0,  ModeDrain, 8'd0,  1'b1, 8'd10,  1'b0},
    '{RowBeat, CfgFrameWidth,  16'd0,  ModeDrain, 8'd0,  1'b1, 8'd10,  1'b0},
    '{RowBeat, CfgFrameWidth,  16'd0,  ModePixel, 8'd0,  1'b1, 8'd20,  1'b1},
    // single pixel frame, capped fill
    '{RowCfg,  CfgBorderFill,  16'd127, ModePixel, 8'd0, 1'b0, 8'd0,   1'b0},
    '{RowCfg,  CfgFrameWidth,  16'd1,  ModePixel, 8'd0,  1'b0, 8'd0,   1'b0},
    '{RowCfg,  CfgFrameHeight, 16'd1,  ModePixel, 8'd0,  1'b0, 8'd0,   1'b0},
    '{RowBeat, CfgFrameWidth,  16'd0,  ModePixel, 8'd200, 1'b0, 8'd0,  1'b0},
    '{RowBeat, CfgFrameWidth,  16'd0,  ModeDrain, 8'd0,  1'b0, 8'd0,   1'b0},
    '{RowBeat, CfgFrameWidth,  16'd0,  ModeDrain, 8'd0,  1'b1, 8'd127, 1'b1},
    // zero width and height act as one
    '{RowCfg,  CfgFrameWidth,  16'd0,  ModePixel, 8'd0,  1'b0, 8'd0,   1'b0},
    '{RowCfg,  CfgFrameHeight, 16'd0,  ModePixel, 8'd0,  1'b0, 8'd0,   1'b0},
    '{RowCfg,  CfgBorderFill,  16'd255, ModePixel, 8'd0, 1'b0, 8'd0,   1'b0},
    '{RowBeat, CfgFrameWidth,  16'd0,  ModePixel, 8'd255, 1'b0, 8'd0,  1'b0},
    '{RowBeat, CfgFrameWidth,  16'd0,  ModeDrain, 8'd0,  1'b0, 8'd0,   1'b0},
    '{RowBeat, CfgFrameWidth,  16'd0,  ModeDrain, 8'd0,  1'b1, 8'd255, 1'b1},
    '{RowBeat, CfgFrameWidth,  16'd0,  ModePixel, 8'd0,  1'b0, 8'd0,   1'b0},
    '{RowBeat, CfgFrameWidth,  16'd0,  ModeDrain, 8'd0,  1'b0, 8'd0,   1'b0},
    '{RowBeat, CfgFrameWidth,  16'd0,  ModePixel, 8'd255, 1'b1, 8'd0,  1'b1}
  };

  logic               clk       = 1'b0;
  logic               rst_n     = 1'b0;
  logic               cfg_we    = 1'b0;
  logic [CfgIdxW-1:0] cfg_index = '0;
  logic [CfgW-1:0]    cfg_data  = '0;
  logic               in_valid  = 1'b0;
  mf3_in_t            in_data   = '0;
  logic               out_ready = 1'b0;
  logic               in_ready;
  logic               out_valid;
  mf3_out_t           out_data;

  min_filter_3x3_unit dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // model state
  logic [FwW-1:0]  fw_reg;
  logic [FhW-1:0]  fh_reg;
  logic [PixW-1:0] fill_reg;
  logic [PixW-1:0] line_up [LineDepth];
  logic [PixW-1:0] line_mid [LineDepth];
  logic [PixW-1:0] win [3][3];
  int unsigned     in_col, in_row, out_col, out_row;

  mf3_out_t    pending_mins [$];
  beat_note_t  beat_notes [$];
  int unsigned fail_count  = 0;
  int unsigned seen_count  = 0;
  int unsigned stalled     = 0;
  int unsigned frame_beats = 0;
  bit          steady      = 1'b0;

  function automatic int unsigned eff_width();
    int unsigned w;
    w = fw_reg;
    if (w == 0) w = 1;
    if (w > LineDepth) w = LineDepth;
    return w;
  endfunction

  function automatic int unsigned eff_height();
    return (fh_reg == 0) ? 1 : fh_reg;
  endfunction

  function automatic logic [PixW-1:0] nbhd_min(int unsigned first, int unsigned w,
                                               int unsigned h);
    logic [PixW-1:0] best;
    logic [PixW-1:0] v;
    bit              row_ok, col_ok;
    best = '1;
    for (int m = 0; m < 3; m++) begin
      for (int n = 0; n < 3; n++) begin
        v = fill_reg;
        row_ok = !((m == 0 && out_row == 0) || (m == 2 && out_row + 1 >= h));
        col_ok = !((n == 0 && out_col == 0) || (n == 2 && out_col + 1 >= w));
        if (row_ok && col_ok && first + n < 3) v = win[m][first + n];
        if (v < best) best = v;
      end
    end
    return best;
  endfunction

  task automatic clear_positions();
    in_col  = 0;
    in_row  = 0;
    out_col = 0;
    out_row = 0;
  endtask

  task automatic model_reset();
    fw_reg   = FrameWidthRst;
    fh_reg   = FrameHeightRst;
    fill_reg = BorderFillRst;
    for (int i = 0; i < LineDepth; i++) begin
      line_up[i]  = BorderFillRst;
      line_mid[i] = BorderFillRst;
    end
    for (int m = 0; m < 3; m++) begin
      for (int n = 0; n < 3; n++) win[m][n] = BorderFillRst;
    end
    clear_positions();
  endtask

  task automatic model_config(logic [CfgIdxW-1:0] idx, logic [CfgW-1:0] val);
    case (idx)
      CfgFrameWidth: begin
        fw_reg = val[FwW-1:0];
        clear_positions();
      end
      CfgFrameHeight: begin
        fh_reg = val[FhW-1:0];
        clear_positions();
      end
      CfgBorderFill: begin
        fill_reg = val[PixW-1:0];
      end
      default: ;
    endcase
  endtask

  task automatic model_step(input logic mode, input logic [PixW-1:0] pix,
                            output bit emitted, output mf3_out_t res);
    int unsigned     w, h, col;
    logic [PixW-1:0] p, top, mid;
    bit              last;
    emitted = 1'b0;
    res     = '0;
    w   = eff_width();
    h   = eff_height();
    col = in_col % LineDepth;
    if (in_row < h) begin
      if (mode == ModeDrain) return;
      p = pix;
    end else begin
      p = fill_reg;
    end
    emitted = (in_row >= 2) || (in_row == 1 && in_col >= 1);
    // at a row start the finished pixel is the last of the row before
    if (emitted && in_col == 0) res.min_value = nbhd_min(1, w, h);
    top = line_up[col];
    mid = line_mid[col];
    line_up[col]  = mid;
    line_mid[col] = p;
    for (int m = 0; m < 3; m++) begin
      win[m][0] = win[m][1];
      win[m][1] = win[m][2];
    end
    win[0][2] = top;
    win[1][2] = mid;
    win[2][2] = p;
    if (emitted && in_col != 0) res.min_value = nbhd_min(0, w, h);
    if (emitted) begin
      last = (out_row + 1 >= h) && (out_col + 1 >= w);
      res.frame_end = last;
      if (last) begin
        clear_positions();
        return;
      end
      out_col++;
      if (out_col >= w) begin
        out_col = 0;
        out_row++;
      end
    end
    in_col++;
    if (in_col >= w) begin
      in_col = 0;
      in_row++;
    end
  endtask

  always @(posedge clk) begin : score
    beat_note_t note;
    mf3_out_t   pred;
    mf3_out_t   want;
    bit         emitted, in_acc, out_acc;
    in_acc  = rst_n && in_valid && in_ready;
    out_acc = rst_n && out_valid && out_ready;
    if (in_acc) begin
      note = beat_notes.pop_front();
      model_step(in_data.mode, in_data.pixel, emitted, pred);
      if (emitted) pending_mins.push_back(note.typed ? note.result : pred);
    end
    if (out_acc) begin
      if (pending_mins.size() == 0) begin
        if (fail_count < 10)
          $display("result %0d with nothing expected: min_value %0d frame_end %0b",
                   seen_count, out_data.min_value, out_data.frame_end);
        fail_count++;
      end else begin
        want = pending_mins.pop_front();
        if (out_data.min_value !== want.min_value ||
            out_data.frame_end !== want.frame_end) begin
          if (fail_count < 10)
            $display("result %0d: min_value exp %0d got %0d, frame_end exp %0b got %0b",
                     seen_count, want.min_value, out_data.min_value,
                     want.frame_end, out_data.frame_end);
          fail_count++;
        end
      end
      seen_count++;
    end
    if (in_acc || out_acc) stalled = 0;
    else if (rst_n) stalled++;
    if (stalled >= WatchdogLimit) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 19);
    if (r < 10) return 0;
    if (r < 18) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  function automatic logic [PixW-1:0] rand_pixel();
    case ($urandom_range(0, 9))
      0:       return 8'd0;
      1:       return 8'd255;
      2:       return PixW'($urandom_range(0, 15));
      default: return PixW'($urandom_range(0, 255));
    endcase
  endfunction

  // result side back-pressure
  initial begin : sink
    int unsigned run, stall;
    forever begin
      if (steady) begin
        out_ready <= 1'b1;
        @(posedge clk);
      end else begin
        run = $urandom_range(1, 20);
        out_ready <= 1'b1;
        repeat (run) @(posedge clk);
        stall = pick_gap();
        if (stall > 0) begin
          out_ready <= 1'b0;
          repeat (stall) @(posedge clk);
        end
      end
    end
  end

  task automatic send_beat(logic mode, logic [PixW-1:0] pixel, beat_note_t note);
    int unsigned gap;
    gap = steady ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    beat_notes.push_back(note);
    in_valid <= 1'b1;
    in_data  <= {mode, pixel};
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic go_quiet();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_mins.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgW-1:0] val);
    cfg_index <= idx;
    cfg_data  <= val;
    cfg_we    <= 1'b1;
    @(posedge clk);
    cfg_we <= 1'b0;
    model_config(idx, val);
    @(posedge clk);
  endtask

  task automatic send_pixels(int unsigned count);
    for (int unsigned i = 0; i < count; i++) begin
      // stray drain inside the frame, dropped by the block
      if (!steady && $urandom_range(0, 29) == 0) send_beat(ModeDrain, rand_pixel(), NoNote);
      send_beat(ModePixel, rand_pixel(), NoNote);
      frame_beats++;
    end
  endtask

  task automatic send_drains();
    int unsigned w;
    w = eff_width();
    for (int unsigned i = 0; i <= w; i++) begin
      if ($urandom_range(0, 3) == 0) send_beat(ModePixel, rand_pixel(), NoNote);
      else send_beat(ModeDrain, rand_pixel(), NoNote);
      frame_beats++;
    end
    if ($urandom_range(0, 4) == 0) send_beat(ModeDrain, rand_pixel(), NoNote);
  endtask

  function automatic logic [CfgW-1:0] rand_width();
    case ($urandom_range(0, 19))
      0:       return 16'd0;
      1:       return 16'd1;
      2:       return 16'd2;
      3, 4:    return CfgW'($urandom_range(16, 40));
      default: return CfgW'($urandom_range(3, 8));
    endcase
  endfunction

  function automatic logic [CfgW-1:0] rand_height();
    case ($urandom_range(0, 9))
      0:       return 16'd0;
      1:       return 16'd1;
      2:       return CfgW'($urandom_range(8, 14));
      default: return CfgW'($urandom_range(2, 5));
    endcase
  endfunction

  function automatic logic [CfgW-1:0] rand_fill();
    case ($urandom_range(0, 5))
      0:       return 16'd0;
      1:       return 16'd127;
      2:       return 16'd255;
      default: return CfgW'($urandom_range(0, 255));
    endcase
  endfunction

  initial begin : stimulus
    beat_note_t  note;
    int unsigned w, h, half, kind;
    model_reset();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < NumRows; i++) begin
      if (Script[i].kind == RowCfg) begin
        go_quiet();
        write_reg(Script[i].index, Script[i].value);
      end else begin
        note.typed            = Script[i].typed;
        note.result.min_value = Script[i].min_value;
        note.result.frame_end = Script[i].frame_end;
        send_beat(Script[i].mode, Script[i].pixel, note);
      end
    end

    frame_beats = 0;
    for (int phase = 0; frame_beats < RandomBeats; phase++) begin
      go_quiet();
      steady = ($urandom_range(0, 4) == 0);
      if (phase == 2) begin
        // widest line, effective width saturates at the line depth
        // a short drain tail reaches the first results, the next width write restarts
        write_reg(CfgFrameWidth, 16'd2047);
        write_reg(CfgFrameHeight, 16'd1);
        send_pixels(eff_width());
        repeat (8) begin
          send_beat(ModeDrain, rand_pixel(), NoNote);
          frame_beats++;
        end
      end else begin
        kind = $urandom_range(0, 9);
        write_reg(CfgFrameWidth, rand_width());
        write_reg(CfgFrameHeight, (kind == 9) ? 16'hFFFF : rand_height());
        if ($urandom_range(0, 1) == 0) write_reg(CfgBorderFill, rand_fill());
        w = eff_width();
        h = eff_height();
        case (kind)
          6, 7: begin
            // broken frame, restarted by the next width write
            send_pixels($urandom_range(1, w * h));
          end
          8: begin
            half = $urandom_range(1, w * h);
            send_pixels(half);
            go_quiet();
            write_reg(CfgBorderFill, rand_fill());
            send_pixels(w * h - half);
            send_drains();
          end
          9: begin
            send_pixels($urandom_range(w + 2, 3 * w + 6));
          end
          default: begin
            repeat ($urandom_range(1, 2)) begin
              send_pixels(w * h);
              send_drains();
            end
          end
        endcase
      end
    end

    steady = 1'b0;
    go_quiet();
    if (fail_count == 0 && pending_mins.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
